@@ sv/jsrm_pkg.sv @@
// Shared types, reset values and the sector-to-relay table for the joystick sector relay mapper.
`timescale 1ns / 1ps

package jsrm_pkg;

    localparam int unsigned AXIS_W   = 8;
    localparam int unsigned RELAY_W  = 6;
    localparam int unsigned SECTOR_W = 4;
    localparam int unsigned SQ_W     = 2 * AXIS_W;   // one axis squared
    localparam int unsigned DIST_W   = SQ_W + 1;     // sum of two squares

    localparam int unsigned S_TDATA_W = 2 * AXIS_W;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned M_PAD_W   = M_TDATA_W - RELAY_W - 1 - SECTOR_W;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER = 2'd0,
        CFG_ENTER  = 2'd1,
        CFG_EXIT   = 2'd2
    } cfg_index_t;

    localparam logic [AXIS_W-1:0] CENTER_RESET = 8'd127;
    // Thresholds are kept squared: (enter+1)^2 and exit^2.
    localparam logic [DIST_W-1:0] ENTER_SQ_RESET = 17'd3721;   // (60+1)^2
    localparam logic [SQ_W-1:0]   EXIT_SQ_RESET  = 16'd1600;   // 40^2

    localparam logic [SECTOR_W-1:0] SECTOR_AT_CENTER = 4'd6;
    localparam logic [SECTOR_W-1:0] SECTOR_RIGHT     = 4'd9;
    localparam logic [SECTOR_W-1:0] SECTOR_MAX       = 4'd11;

    typedef logic [RELAY_W-1:0]  relay_mask_t;
    typedef logic [SECTOR_W-1:0] sector_t;

    function automatic relay_mask_t relay_lookup(input sector_t sector);
        relay_mask_t mask;
        unique case (sector)
            4'd0:    mask = 6'h08;
            4'd1:    mask = 6'h18;
            4'd2:    mask = 6'h10;
            4'd3:    mask = 6'h30;
            4'd4:    mask = 6'h20;
            4'd5:    mask = 6'h21;
            4'd6:    mask = 6'h01;
            4'd7:    mask = 6'h03;
            4'd8:    mask = 6'h02;
            4'd9:    mask = 6'h06;
            4'd10:   mask = 6'h04;
            4'd11:   mask = 6'h0C;
            default: mask = '0;
        endcase
        return mask;
    endfunction

endpackage

@@ sv/joystick_sector_relay_mapper.sv @@
// Top level: joystick sample to direction sector and relay mask, with hysteresis.
`timescale 1ns / 1ps

//  channel  | direction | beat contents (lowest bits first)
//  ---------+-----------+---------------------------------------------------------
//  s_axis   | in        | x_position[7:0], y_position[15:8]
//  m_axis   | out       | relay_mask[5:0], stick_active[6], direction_sector[10:7]
//  cfg_wr   | in        | index 0 center_value, 1 enter_radius, 2 exit_radius
//
//  One sample per clock while the sink keeps up; path: input register, then the
//  single compute stage, then the result register.
//  aresetn (synchronous) clears the deflected flag and both valids and restores
//  the register defaults 127 / 60 / 40.
//  A stalled result holds in the result register while one more sample waits in
//  the input register; s_tready drops only when both are full.

module joystick_sector_relay_mapper
    import jsrm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,    // x_position[7:0], y_position[15:8]

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,    // relay_mask[5:0], stick_active[6],
                                               // direction_sector[10:7], zero[15:11]

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    // ------------------------------------------------------------------
    // Configuration: keep the center and the two thresholds already squared
    // ------------------------------------------------------------------
    logic [AXIS_W-1:0] center_reg;
    logic [DIST_W-1:0] enter_sq_reg;
    logic [SQ_W-1:0]   exit_sq_reg;

    logic [AXIS_W:0]     enter_plus_one;
    logic [2*AXIS_W+1:0] enter_sq_full;
    logic [SQ_W-1:0]     exit_sq_full;

    assign enter_plus_one = {1'b0, cfg_wr_data} + 9'd1;
    assign enter_sq_full  = {{(AXIS_W+1){1'b0}}, enter_plus_one} *
                            {{(AXIS_W+1){1'b0}}, enter_plus_one};
    assign exit_sq_full   = {{AXIS_W{1'b0}}, cfg_wr_data} * {{AXIS_W{1'b0}}, cfg_wr_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg   <= CENTER_RESET;
            enter_sq_reg <= ENTER_SQ_RESET;
            exit_sq_reg  <= EXIT_SQ_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_CENTER: center_reg   <= cfg_wr_data;
                CFG_ENTER:  enter_sq_reg <= enter_sq_full[DIST_W-1:0];
                CFG_EXIT:   exit_sq_reg  <= exit_sq_full;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register in one step
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic [AXIS_W-1:0] x_reg;
    logic [AXIS_W-1:0] y_reg;
    logic              m_valid_reg;
    logic              advance;
    logic              process;

    // Advance whenever the result register is free or being drained this cycle.
    assign advance  = !m_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            x_reg <= s_tdata[AXIS_W-1:0];
            y_reg <= s_tdata[2*AXIS_W-1:AXIS_W];
        end
    end

    // ------------------------------------------------------------------
    // Compute stage
    // ------------------------------------------------------------------
    logic [AXIS_W:0]   dx;        // two's complement, -255..255
    logic [AXIS_W:0]   dy;
    logic              dx_neg, dy_neg, dx_zero, dy_zero;
    logic [AXIS_W-1:0] abs_x, abs_y;
    logic [SQ_W-1:0]   a2, b2;
    logic [DIST_W:0]   a2_x3, b2_x3;
    logic [DIST_W-1:0] dist_sq;
    logic [1:0]        step;
    logic              flag_reg;
    logic              flag_next;
    sector_t           sector_raw;
    sector_t           sector_next;
    relay_mask_t       mask_next;

    assign dx      = {1'b0, x_reg} - {1'b0, center_reg};
    assign dy      = {1'b0, y_reg} - {1'b0, center_reg};
    assign dx_neg  = dx[AXIS_W];
    assign dy_neg  = dy[AXIS_W];
    assign dx_zero = (dx == '0);
    assign dy_zero = (dy == '0);
    assign abs_x   = dx_neg ? AXIS_W'(-dx) : dx[AXIS_W-1:0];
    assign abs_y   = dy_neg ? AXIS_W'(-dy) : dy[AXIS_W-1:0];
    assign a2      = {{AXIS_W{1'b0}}, abs_x} * {{AXIS_W{1'b0}}, abs_x};
    assign b2      = {{AXIS_W{1'b0}}, abs_y} * {{AXIS_W{1'b0}}, abs_y};
    assign dist_sq = {1'b0, a2} + {1'b0, b2};
    assign a2_x3   = {1'b0, a2, 1'b0} + {2'b00, a2};
    assign b2_x3   = {1'b0, b2, 1'b0} + {2'b00, b2};

    // Step within a quadrant: under 30 degrees off the y axis, under 60, or beyond.
    always_comb begin
        priority if (a2_x3 < {2'b00, b2}) begin
            step = 2'd0;
        end else if ({2'b00, a2} < b2_x3) begin
            step = 2'd1;
        end else begin
            step = 2'd2;
        end
    end

    // Hysteresis: an idle stick may only set, a deflected stick may only clear.
    always_comb begin
        if (!flag_reg) begin
            flag_next = (dist_sq >= enter_sq_reg);
        end else begin
            flag_next = !(dist_sq < {1'b0, exit_sq_reg});
        end
    end

    // Quadrant folding; straight down lands on the top sector without a clamp.
    always_comb begin
        priority if (!dx_neg && !dy_neg) begin
            priority if (dy_zero && !dx_zero) begin
                sector_raw = SECTOR_RIGHT;
            end else if (dx_zero && dy_zero) begin
                sector_raw = SECTOR_AT_CENTER;
            end else begin
                sector_raw = 4'd6 + {2'b00, step};
            end
        end else if (!dx_neg) begin
            sector_raw = SECTOR_MAX - {2'b00, step};
        end else if (!dy_neg) begin
            sector_raw = 4'd5 - {2'b00, step};
        end else begin
            sector_raw = {2'b00, step};
        end
    end

    assign sector_next = flag_next ? sector_raw : '0;
    assign mask_next   = flag_next ? relay_lookup(sector_raw) : '0;

    // ------------------------------------------------------------------
    // State and result register
    // ------------------------------------------------------------------
    relay_mask_t mask_reg;
    logic        active_reg;
    sector_t     sector_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (process) begin
                flag_reg <= flag_next;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            mask_reg   <= mask_next;
            active_reg <= flag_next;
            sector_reg <= sector_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, sector_reg, active_reg, mask_reg};

`ifndef SYNTH
    // The deflected flag moves only when a sample passes through the compute stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !process |=> $stable(flag_reg))
        else $error("deflected flag changed without a sample");

    // An idle stick reports neither relays nor a sector.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[RELAY_W]) |->
            (m_tdata[RELAY_W-1:0] == '0 && m_tdata[RELAY_W+SECTOR_W:RELAY_W+1] == '0))
        else $error("inactive result carries a mask or sector");

    // A deflected stick drives one or two neighboring relays in a valid sector.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[RELAY_W]) |->
            (m_tdata[RELAY_W+SECTOR_W:RELAY_W+1] <= SECTOR_MAX &&
             m_tdata[RELAY_W-1:0] != '0 &&
             $countones(m_tdata[RELAY_W-1:0]) <= 2))
        else $error("active result has a bad sector or mask");

    // Input stalls only when both registers are full and the sink is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled with room available");
`endif

endmodule
